// File: sv/bst_pkg.sv
// Shared types and constants for the bounded set table.
// Used by the controller, the datapath, the top level and the checker.
package bst_pkg;

  localparam int VALUE_W = 32;
  localparam int OP_W    = 2;
  localparam int POS_W   = 4;
  localparam int LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic               success;
    logic [POS_W-1:0]   position;
    logic [LIMIT_W-1:0] entry_count;
    logic               is_full;
    logic               is_empty;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;    // capture the incoming item
    logic exec;    // compare, update the cells and load the result
    logic cfg_we;  // write the capacity limit
  } dp_cmd_t;

endpackage

// File: sv/bounded_set_table.sv
// Bounded set table: a set of distinct 32-bit signed values kept in insertion
// order, with a writable capacity limit (reset 16, saturating at CAPACITY).
// Each item is an insert, remove or lookup and yields one result. An item is
// first captured, then executed: all cells are compared in parallel and the
// append or the shift-down is written back together with the result register.
// A new item is not taken until the last one has been executed.
// The execute step waits while an earlier result is still stalled at the
// output. Entries are registers that reset leaves undefined; only the count
// is cleared and the limit set to 16. cfg_ready is always high.
module bounded_set_table #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bst_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bst_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bst_pkg::LIMIT_W-1:0] cfg_data
);
  import bst_pkg::*;

  dp_cmd_t cmd;

  bst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  bst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule

// File: sv/bst_ctrl.sv
// Controller for the bounded set table: handshakes and sequencing.
// Depends on bst_pkg for the state and command types.
module bst_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  output bst_pkg::dp_cmd_t cmd
);
  import bst_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The result register can take a new value when empty or being drained
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd        = '0;
    cmd.cfg_we = cfg_valid;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

endmodule

// File: sv/bst_dp.sv
// Datapath for the bounded set table: value cells, count, limit and result.
// Depends on bst_pkg; driven by the command struct from bst_ctrl.
module bst_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bst_pkg::in_t                in_data,
  input  logic [bst_pkg::LIMIT_W-1:0] cfg_data,
  input  bst_pkg::dp_cmd_t            cmd,
  output bst_pkg::out_t               out_data
);
  import bst_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int EW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int PW = (IW > POS_W) ? IW : POS_W;

  in_t                item_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [VALUE_W-1:0] cell_r   [CAPACITY];
  logic [VALUE_W-1:0] cell_nxt [CAPACITY];
  out_t               out_r, out_nxt;

  logic [CAPACITY-1:0] hit;
  logic                found;
  logic [IW-1:0]       where;
  logic [EW-1:0]       eff_limit, limit_ext, count_ext, count_nxt_ext;
  logic [PW-1:0]       where_ext;
  logic                do_ins, do_rem, look_hit;

  // Parallel compare over the live cells; values are distinct so at most one hits
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = (cell_r[i] == item_r.value) && (CW'(i) < count_r);
    end
  end

  always_comb begin
    where = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) where = where | IW'(i);
    end
  end

  assign found     = |hit;
  assign limit_ext = EW'(limit_r);
  assign eff_limit = (limit_ext > EW'(CAPACITY)) ? EW'(CAPACITY) : limit_ext;
  assign count_ext = EW'(count_r);

  assign do_ins   = (item_r.op == OP_INSERT) && !found && (count_ext < eff_limit);
  assign do_rem   = (item_r.op == OP_REMOVE) && found;
  assign look_hit = (item_r.op == OP_LOOKUP) && found;

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Append at the count, or close the gap by moving later cells down one place
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      if (do_ins && (CW'(i) == count_r)) begin
        cell_nxt[i] = item_r.value;
      end else if (do_rem && (i < CAPACITY - 1) && (IW'(i) >= where)) begin
        cell_nxt[i] = cell_r[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  assign count_nxt_ext = EW'(count_nxt);
  assign where_ext     = PW'(where);

  always_comb begin
    out_nxt             = '0;
    out_nxt.success     = do_ins || do_rem || look_hit;
    out_nxt.position    = look_hit ? where_ext[POS_W-1:0] : '0;
    out_nxt.entry_count = count_nxt_ext[LIMIT_W-1:0];
    out_nxt.is_full     = (count_nxt_ext >= eff_limit);
    out_nxt.is_empty    = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      limit_r <= LIMIT_RESET;
    end else begin
      if (cmd.exec)   count_r <= count_nxt;
      if (cmd.cfg_we) limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.exec) begin
      cell_r <= cell_nxt;
      out_r  <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// File: sv/bst_checker.sv
// Port-level checks for the bounded set table, bound to the top level.
// Depends on bst_pkg for the payload types.
module bst_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input bst_pkg::out_t out_data
);
  import bst_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  // One item in flight: the cycle after a transfer in is never another transfer in
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in flight");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> out_data.entry_count == '0)
    else $error("empty flag with non-zero count");

  a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.success |-> out_data.position == '0)
    else $error("failed operation reports a position");

endmodule

bind bounded_set_table bst_checker u_bst_checker (.*);

// File: tb/sv/bounded_set_table_test.sv
// Self-checking testbench for the bounded set table: directed rows, then random
// phases at several capacity limits, checked against a behavioural model or typed rows.
// Depends on bst_pkg and bounded_set_table.
module bounded_set_table_test;
  import bst_pkg::*;

  localparam int TABLE_DEPTH   = 16;
  localparam int POOL_SIZE     = 20;
  localparam int PHASE_ITEMS   = 100;
  localparam int N_PHASE       = 11;
  localparam int WATCHDOG_LIM  = 2000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7fff_ffff;

  localparam logic [LIMIT_W-1:0] PHASE_LIMIT [N_PHASE] = '{
    5'd1, 5'd0, 5'd31, 5'd16, 5'd3, 5'd17, 5'd2, 5'd15, 5'd8, 5'd16, 5'd5
  };

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic                      typed;
    out_t                      want;
  } dir_row_t;

  localparam int N_DIR = 20;
  dir_row_t dir_rows [N_DIR] = '{
    '{OP_LOOKUP, 32'sd0,         1'b1, '{1'b0, 4'd0, 5'd0, 1'b0, 1'b1}},
    '{OP_REMOVE, 32'sd0,         1'b1, '{1'b0, 4'd0, 5'd0, 1'b0, 1'b1}},
    '{OP_INSERT, V_MIN,          1'b1, '{1'b1, 4'd0, 5'd1, 1'b0, 1'b0}},
    '{OP_INSERT, V_MAX,          1'b1, '{1'b1, 4'd0, 5'd2, 1'b0, 1'b0}},
    '{OP_INSERT, V_MAX,          1'b1, '{1'b0, 4'd0, 5'd2, 1'b0, 1'b0}},
    '{OP_LOOKUP, V_MAX,          1'b1, '{1'b1, 4'd1, 5'd2, 1'b0, 1'b0}},
    '{OP_LOOKUP, 32'sd0,         1'b1, '{1'b0, 4'd0, 5'd2, 1'b0, 1'b0}},
    '{OP_UNUSED, V_MAX,          1'b1, '{1'b0, 4'd0, 5'd2, 1'b0, 1'b0}},
    '{OP_INSERT, 32'sd0,         1'b1, '{1'b1, 4'd0, 5'd3, 1'b0, 1'b0}},
    '{OP_INSERT, -32'sd1,        1'b1, '{1'b1, 4'd0, 5'd4, 1'b0, 1'b0}},
    '{OP_INSERT, 32'sh5555_5555, 1'b0, '0},
    '{OP_INSERT, 32'shaaaa_aaaa, 1'b0, '0},
    '{OP_LOOKUP, -32'sd1,        1'b0, '0},
    '{OP_REMOVE, V_MAX,          1'b1, '{1'b1, 4'd0, 5'd5, 1'b0, 1'b0}},
    '{OP_LOOKUP, 32'shaaaa_aaaa, 1'b0, '0},
    '{OP_REMOVE, V_MIN,          1'b1, '{1'b1, 4'd0, 5'd4, 1'b0, 1'b0}},
    '{OP_REMOVE, V_MIN,          1'b1, '{1'b0, 4'd0, 5'd4, 1'b0, 1'b0}},
    '{OP_LOOKUP, 32'sd0,         1'b0, '0},
    '{OP_REMOVE, 32'shaaaa_aaaa, 1'b0, '0},
    '{OP_UNUSED, 32'sd0,         1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  bounded_set_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state of the set
  logic signed [VALUE_W-1:0] held_vals [TABLE_DEPTH];
  logic [LIMIT_W-1:0]        held_cnt = '0;
  logic [LIMIT_W-1:0]        cap_limit = LIMIT_RESET;

  out_t                      pending_results [$];
  logic signed [VALUE_W-1:0] value_pool [POOL_SIZE];
  int                        errors = 0;
  int                        quiet_cycles = 0;
  int                        stall_left = 0;
  bit                        idle_on = 1'b1;

  function automatic out_t predict_table_op(input in_t item);
    out_t               r;
    int                 hit;
    logic [LIMIT_W-1:0] eff;
    eff = (cap_limit > TABLE_DEPTH) ? LIMIT_W'(TABLE_DEPTH) : cap_limit;
    hit = -1;
    for (int i = 0; i < int'(held_cnt); i++) begin
      if (hit < 0 && held_vals[i] == item.value) hit = i;
    end
    r = '0;
    case (item.op)
      OP_INSERT: begin
        if (hit < 0 && held_cnt < eff) begin
          held_vals[held_cnt] = item.value;
          held_cnt = held_cnt + 1'b1;
          r.success = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          // close the gap, keeping insertion order
          for (int j = hit; j + 1 < int'(held_cnt); j++) held_vals[j] = held_vals[j + 1];
          held_cnt = held_cnt - 1'b1;
          r.success = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (hit >= 0) begin
          r.success  = 1'b1;
          r.position = POS_W'(hit);
        end
      end
      default: ;
    endcase
    r.entry_count = held_cnt;
    r.is_full     = (held_cnt >= eff);
    r.is_empty    = (held_cnt == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got %p", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("success",     want.success,     out_data.success);
        check_field("position",    want.position,    out_data.position);
        check_field("entry_count", want.entry_count, out_data.entry_count);
        check_field("is_full",     want.is_full,     out_data.is_full);
        check_field("is_empty",    want.is_empty,    out_data.is_empty);
      end
    end
  end

  // Receiver back-pressure in random bursts, only while idle_on is set
  always @(negedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 11) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIM) begin
      $display("** bounded_set_table: FAILED **");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input in_t item, input logic typed, input out_t want);
    out_t predicted;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predicted = predict_table_op(item);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] limit);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    cap_limit = limit;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t random_item(input int ins_pct);
    in_t item;
    int  r;
    r = $urandom_range(0, 99);
    if (r < ins_pct)                            item.op = OP_INSERT;
    else if (r < ins_pct + (95 - ins_pct) / 2)  item.op = OP_REMOVE;
    else if (r < 95)                            item.op = OP_LOOKUP;
    else                                        item.op = OP_UNUSED;
    // mostly pool values so hits happen; the rest is full-range noise
    if ($urandom_range(0, 9) == 0) item.value = $urandom;
    else item.value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return item;
  endfunction

  initial begin
    in_t item;
    int  ins_pct;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      item.op    = dir_rows[i].op;
      item.value = dir_rows[i].value;
      send_item(item, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < N_PHASE; p++) begin
      drain_results();
      write_limit(PHASE_LIMIT[p]);
      idle_on = (p % 3 != 2) && (p != N_PHASE - 1);
      ins_pct = (PHASE_LIMIT[p] >= 16) ? 65 : 40;
      value_pool[0] = V_MIN;
      value_pool[1] = V_MAX;
      value_pool[2] = 32'sd0;
      value_pool[3] = -32'sd1;
      for (int i = 4; i < POOL_SIZE; i++)
        value_pool[i] = (i % 2 == 0) ? $urandom : $signed($urandom_range(0, 40)) - 20;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (idle_on && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        send_item(random_item(ins_pct), 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (errors == 0)
      $display("** bounded_set_table: PASSED **");
    else
      $display("** bounded_set_table: FAILED **");
    $finish;
  end

endmodule

// File: files.f
sv/bst_pkg.sv
sv/bst_ctrl.sv
sv/bst_dp.sv
sv/bounded_set_table.sv
sv/bst_checker.sv
tb/sv/bounded_set_table_test.sv
